// ===== src/slps_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and step functions for the status led pattern sequencer
// no dependencies; used by every other file of the block except slps_if

package slps_pkg;

  localparam int BreathSteps = 120;
  localparam int DelayBits   = 13;

  localparam logic [3:0] CFG_ADDR_W = 4'd4;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_TRIGGER = 3'd1,
    REQ_KEY     = 3'd2,
    REQ_LAYER   = 3'd3,
    REQ_CYCLE   = 3'd4,
    REQ_SLEEP   = 3'd5,
    REQ_WAKE    = 3'd6,
    REQ_USB     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    TRIG_PROFILE = 2'd0,
    TRIG_CHARGE  = 2'd1,
    TRIG_BOTH    = 2'd2,
    TRIG_NONE    = 2'd3
  } trig_t;

  typedef enum logic [2:0] {
    SM_IDLE        = 3'd0,
    SM_ADV         = 3'd1,
    SM_LINK        = 3'd2,
    SM_CHARGE      = 3'd3,
    SM_BOTH_LINK   = 3'd4,
    SM_BOTH_PAUSE  = 3'd5,
    SM_BOTH_CHARGE = 3'd6,
    SM_PREVIEW_OFF = 3'd7
  } sm_t;

  typedef enum logic [1:0] {
    GM_OFF     = 2'd0,
    GM_DIM     = 2'd1,
    GM_BREATHE = 2'd2
  } gm_t;

  typedef enum logic [1:0] {
    REG_MOUSE_LAYER = 2'd0,
    REG_GLOW_LIMIT  = 2'd1,
    REG_PWM_PERIOD  = 2'd2,
    REG_DIM_ON      = 2'd3
  } reg_t;

  typedef struct packed {
    logic [4:0] mouse_layer;
    logic [6:0] glow_charge_limit;
    logic [4:0] pwm_period_ms;
    logic [2:0] dim_on_ms;
  } cfg_t;

  typedef struct packed {
    logic       usb;
    logic       link;
    logic [2:0] profile;
    logic [6:0] charge;
  } live_t;

  typedef struct packed {
    sm_t                  seq_mode;
    logic [3:0]           seq_step;
    logic [2:0]           pulse_target;
    logic                 link_latched;
    logic                 long_pulse;
    logic                 sleeping;
    logic [DelayBits-1:0] seq_delay;
    logic [4:0]           glow_delay;
    gm_t                  glow_mode;
    logic                 layer_active;
    logic                 preview_on;
    logic [6:0]           preview_left;
    logic [4:0]           pwm_delay;
    logic                 pwm_high;
    logic [6:0]           breath_index;
    logic [2:0]           on_ticks;
    logic                 led_level;
    logic                 kick;
  } st_t;

  localparam st_t ST_RESET = '{
    seq_mode: SM_IDLE, seq_step: 4'd0, pulse_target: 3'd0, link_latched: 1'b0,
    long_pulse: 1'b0, sleeping: 1'b0, seq_delay: '0, glow_delay: 5'd0,
    glow_mode: GM_DIM, layer_active: 1'b0, preview_on: 1'b0, preview_left: 7'd0,
    pwm_delay: 5'd0, pwm_high: 1'b0, breath_index: 7'd0, on_ticks: 3'd0,
    led_level: 1'b0, kick: 1'b0};

  // duty table of the breathing glow, in on ticks per period
  function automatic logic [2:0] breath_duty(input logic [6:0] idx);
    logic [2:0] d;
    if (idx < 7'd6)       d = 3'd1;
    else if (idx < 7'd12) d = 3'd2;
    else if (idx < 7'd18) d = 3'd3;
    else if (idx < 7'd23) d = 3'd4;
    else if (idx < 7'd29) d = 3'd5;
    else if (idx < 7'd46) d = 3'd6;
    else if (idx < 7'd52) d = 3'd5;
    else if (idx < 7'd57) d = 3'd4;
    else if (idx < 7'd63) d = 3'd3;
    else if (idx < 7'd69) d = 3'd2;
    else                  d = 3'd1;
    return d;
  endfunction

  function automatic logic [DelayBits-1:0] dly(input int unsigned ms);
    return DelayBits'(ms);
  endfunction

  function automatic st_t start_adv(input st_t s, input live_t lv);
    st_t r;
    r = s;
    if (!(r.seq_mode >= SM_LINK || lv.usb)) begin
      r.seq_mode  = SM_ADV;
      r.seq_step  = 4'd0;
      r.seq_delay = dly(100);
    end
    return r;
  endfunction

  function automatic st_t start_pwm(input st_t s);
    st_t r;
    r = s;
    if (!(r.sleeping || r.seq_mode >= SM_LINK)) begin
      if (r.glow_mode == GM_OFF && !r.preview_on) begin
        r.led_level = 1'b0;
      end else begin
        r.pwm_high     = 1'b0;
        r.breath_index = 7'd0;
        r.pwm_delay    = 5'd0;
        r.kick         = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic st_t stop_pwm(input st_t s);
    st_t r;
    r = s;
    r.pwm_delay  = 5'd0;
    r.kick       = 1'b0;
    r.pwm_high   = 1'b0;
    r.preview_on = 1'b0;
    if (r.seq_mode < SM_LINK) r.led_level = 1'b0;
    return r;
  endfunction

  function automatic st_t settle(input st_t s, input live_t lv);
    st_t r;
    r = s;
    if (r.layer_active && r.glow_mode != GM_OFF) begin
      r = start_pwm(r);
    end else begin
      r.led_level = 1'b0;
      r.seq_mode  = SM_IDLE;
      if (!lv.usb && !lv.link) r = start_adv(r, lv);
    end
    return r;
  endfunction

  function automatic st_t pwm_fire(input st_t s, input cfg_t c, input live_t lv);
    st_t r;
    logic done;
    r = s;
    done = 1'b0;
    if (r.sleeping || r.seq_mode >= SM_LINK || (!r.layer_active && !r.preview_on)) begin
      r.led_level = 1'b0;
      r.pwm_high  = 1'b0;
      done = 1'b1;
    end else if (r.pwm_high) begin
      r.led_level = 1'b0;
      r.pwm_high  = 1'b0;
      r.pwm_delay = (c.pwm_period_ms > {2'b00, r.on_ticks}) ?
                    c.pwm_period_ms - {2'b00, r.on_ticks} : 5'd1;
      done = 1'b1;
    end else if (r.preview_on) begin
      if (r.preview_left != 7'd0) begin
        r.preview_left = r.preview_left - 7'd1;
      end else begin
        r.preview_on = 1'b0;
        r.led_level  = 1'b0;
        r.pwm_high   = 1'b0;
        r = settle(r, lv);
        done = 1'b1;
      end
    end
    if (!done) begin
      unique case (r.glow_mode)
        GM_DIM: r.on_ticks = c.dim_on_ms;
        GM_BREATHE: begin
          r.on_ticks = breath_duty(r.breath_index);
          r.breath_index = ({1'b0, r.breath_index} + 8'd1 >= 8'(BreathSteps)) ?
                           7'd0 : r.breath_index + 7'd1;
        end
        default: r.on_ticks = 3'd0;
      endcase
      if (r.on_ticks == 3'd0) begin
        r.led_level = 1'b0;
        r.pwm_high  = 1'b0;
        r.pwm_delay = (c.pwm_period_ms != 5'd0) ? c.pwm_period_ms : 5'd1;
      end else begin
        r.led_level = 1'b1;
        r.pwm_high  = 1'b1;
        r.pwm_delay = {2'b00, r.on_ticks};
      end
    end
    return r;
  endfunction

  function automatic st_t begin_link(input st_t s, input live_t lv, input sm_t m);
    st_t r;
    r = s;
    r.link_latched = lv.link;
    r.pulse_target = ((lv.profile > 3'd4) ? 3'd4 : lv.profile) + 3'd1;
    r.seq_step     = 4'd0;
    r.seq_mode     = m;
    r.long_pulse   = 1'b0;
    r.seq_delay    = dly(50);
    return r;
  endfunction

  function automatic st_t begin_charge(input st_t s, input live_t lv, input sm_t m);
    st_t r;
    r = s;
    r.long_pulse = 1'b0;
    if (lv.charge >= 7'd75)      r.pulse_target = 3'd4;
    else if (lv.charge >= 7'd50) r.pulse_target = 3'd3;
    else if (lv.charge >= 7'd25) r.pulse_target = 3'd2;
    else begin
      r.pulse_target = 3'd1;
      r.long_pulse   = 1'b1;
    end
    r.seq_step  = 4'd0;
    r.seq_mode  = m;
    r.seq_delay = dly(50);
    return r;
  endfunction

  function automatic st_t seq_fire(input st_t s, input live_t lv);
    st_t r;
    logic [3:0] last;
    r = s;
    last = {r.pulse_target, 1'b0};
    if (r.sleeping) begin
      r.led_level = 1'b0;
      r.seq_mode  = SM_IDLE;
    end else begin
      unique case (r.seq_mode)
        SM_PREVIEW_OFF: begin
          r.led_level = 1'b0;
          r = settle(r, lv);
        end
        SM_LINK, SM_BOTH_LINK: begin
          if (r.seq_step < last) begin
            r.led_level = ~r.seq_step[0];
            r.seq_delay = r.seq_step[0] ? dly(180) : dly(120);
            r.seq_step  = r.seq_step + 4'd1;
          end else if (r.seq_step == last && r.link_latched) begin
            r.led_level = 1'b1;
            r.seq_step  = r.seq_step + 4'd1;
            r.seq_delay = dly(600);
          end else begin
            r.led_level = 1'b0;
            if (r.seq_mode == SM_BOTH_LINK) begin
              r.seq_mode  = SM_BOTH_PAUSE;
              r.seq_delay = dly(800);
            end else begin
              r = settle(r, lv);
            end
          end
        end
        SM_BOTH_PAUSE: begin
          r.led_level = 1'b0;
          r = begin_charge(r, lv, SM_BOTH_CHARGE);
        end
        SM_CHARGE, SM_BOTH_CHARGE: begin
          if (r.seq_step < last) begin
            r.led_level = ~r.seq_step[0];
            r.seq_delay = r.seq_step[0] ? dly(200) : (r.long_pulse ? dly(500) : dly(150));
            r.seq_step  = r.seq_step + 4'd1;
          end else begin
            r = settle(r, lv);
          end
        end
        SM_ADV: begin
          // double blink: 50 on, 100 off, 50 on, 4800 off
          if (r.seq_step == 4'd0) begin
            r.led_level = 1'b1; r.seq_step = 4'd1; r.seq_delay = dly(50);
          end else if (r.seq_step == 4'd1) begin
            r.led_level = 1'b0; r.seq_step = 4'd2; r.seq_delay = dly(100);
          end else if (r.seq_step == 4'd2) begin
            r.led_level = 1'b1; r.seq_step = 4'd3; r.seq_delay = dly(50);
          end else begin
            r.led_level = 1'b0; r.seq_step = 4'd0; r.seq_delay = dly(4800);
          end
        end
        default: r = settle(r, lv);
      endcase
    end
    return r;
  endfunction

  function automatic st_t glow_fire(input st_t s);
    st_t r;
    r = s;
    if (r.sleeping) r.led_level = 1'b0;
    else if (r.layer_active && r.glow_mode != GM_OFF) r = start_pwm(r);
    else if (r.seq_mode < SM_LINK) r.led_level = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/slps_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result transactions
// depends on nothing but plain logic types

interface slps_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] trigger_kind;
  logic [4:0] layer_number;
  logic       layer_on;
  logic       usb_powered;
  logic       link_connected;
  logic [2:0] profile_index;
  logic [6:0] charge_percent;

  modport source (output valid, req_type, trigger_kind, layer_number, layer_on,
                  usb_powered, link_connected, profile_index, charge_percent,
                  input ready);
  modport sink (input valid, req_type, trigger_kind, layer_number, layer_on,
                usb_powered, link_connected, profile_index, charge_percent,
                output ready);
endinterface

interface slps_out_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic [2:0] show_mode;
  logic [1:0] glow_mode;
  logic       asleep;

  modport source (output valid, led_on, show_mode, glow_mode, asleep, input ready);
  modport sink (input valid, led_on, show_mode, glow_mode, asleep, output ready);
endinterface

// ===== src/status_led_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// top level of the status led pattern sequencer: state register and result register
// depends on slps_pkg, slps_if, slps_cfg and slps_step

// Every request transaction (tick, trigger, key, layer, mode cycle, sleep, wake, usb)
// is applied to the sequencer state by combinational next-state logic and gives one result
// transaction with the led level, sequencer mode, glow mode and sleep flag after it.
// The block takes one request per cycle while its output is not stalled: the result sits in an output register, and
// a new request is taken whenever that register is empty or is being read in the same
// cycle, and the result is registered in the cycle after the request is accepted.
// The user must write the configuration registers over the apb port only while no transaction is pending; not enforced.
module status_led_pattern_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  slps_in_if.sink                         in_ch,
  slps_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import slps_pkg::*;

  cfg_t  cfg;
  live_t lv;
  st_t   st_r, st_nxt;
  logic  out_valid_r;
  logic  led_r;
  sm_t   mode_r;
  gm_t   glow_r;
  logic  asleep_r;
  logic  accept;

  slps_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign lv = '{usb: in_ch.usb_powered, link: in_ch.link_connected,
                profile: in_ch.profile_index, charge: in_ch.charge_percent};

  slps_step u_step (
    .st(st_r), .cfg, .lv,
    .req_type(in_ch.req_type), .trigger_kind(in_ch.trigger_kind),
    .layer_number(in_ch.layer_number), .layer_on(in_ch.layer_on),
    .st_nxt
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) st_r <= st_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_r    <= st_nxt.led_level;
      mode_r   <= st_nxt.seq_mode;
      glow_r   <= st_nxt.glow_mode;
      asleep_r <= st_nxt.sleeping;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.led_on    = led_r;
  assign out_ch.show_mode = mode_r;
  assign out_ch.glow_mode = glow_r;
  assign out_ch.asleep    = asleep_r;
endmodule

// ===== src/slps_cfg.sv =====
`timescale 1ns / 1ps
// apb-style register file for the four configuration registers
// depends on slps_pkg

module slps_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output slps_pkg::cfg_t                    cfg
);
  import slps_pkg::*;

  cfg_t cfg_r;
  reg_t idx;
  logic wr_en;

  assign idx    = reg_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mouse_layer: 5'd4, glow_charge_limit: 7'd20,
                 pwm_period_ms: 5'd20, dim_on_ms: 3'd2};
    end else if (wr_en) begin
      unique case (idx)
        REG_MOUSE_LAYER: cfg_r.mouse_layer       <= pwdata[4:0];
        REG_GLOW_LIMIT:  cfg_r.glow_charge_limit <= pwdata[6:0];
        REG_PWM_PERIOD:  cfg_r.pwm_period_ms     <= pwdata[4:0];
        REG_DIM_ON:      cfg_r.dim_on_ms         <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOUSE_LAYER: prdata = {27'd0, cfg_r.mouse_layer};
      REG_GLOW_LIMIT:  prdata = {25'd0, cfg_r.glow_charge_limit};
      REG_PWM_PERIOD:  prdata = {27'd0, cfg_r.pwm_period_ms};
      REG_DIM_ON:      prdata = {29'd0, cfg_r.dim_on_ms};
      default:         prdata = 32'd0;
    endcase
  end
endmodule

// ===== src/slps_step.sv =====
`timescale 1ns / 1ps
// next-state logic: applies one request transaction to the sequencer state
// depends on slps_pkg

module slps_step (
  input  slps_pkg::st_t   st,
  input  slps_pkg::cfg_t  cfg,
  input  slps_pkg::live_t lv,
  input  logic [2:0]      req_type,
  input  logic [1:0]      trigger_kind,
  input  logic [4:0]      layer_number,
  input  logic            layer_on,
  output slps_pkg::st_t   st_nxt
);
  import slps_pkg::*;

  always_comb begin
    st_t s;
    s = st;
    s.kick = 1'b0;
    unique case (req_t'(req_type))
      REQ_TICK: begin
        // timers count in order: sequence, key flash, pwm
        if (s.seq_delay != '0) begin
          s.seq_delay = s.seq_delay - 1'b1;
          if (s.seq_delay == '0) s = seq_fire(s, lv);
        end
        if (s.glow_delay != 5'd0) begin
          s.glow_delay = s.glow_delay - 5'd1;
          if (s.glow_delay == 5'd0) s = glow_fire(s);
        end
        if (s.pwm_delay != 5'd0) begin
          s.pwm_delay = s.pwm_delay - 5'd1;
          if (s.pwm_delay == 5'd0) s = pwm_fire(s, cfg, lv);
        end
      end
      REQ_TRIGGER: begin
        if (!s.sleeping) begin
          s = stop_pwm(s);
          s.seq_delay  = '0;
          s.glow_delay = 5'd0;
          s.led_level  = 1'b0;
          unique case (trig_t'(trigger_kind))
            TRIG_PROFILE: s = begin_link(s, lv, SM_LINK);
            TRIG_CHARGE:  s = begin_charge(s, lv, SM_CHARGE);
            TRIG_BOTH:    s = begin_link(s, lv, SM_BOTH_LINK);
            default: ;
          endcase
        end
      end
      REQ_KEY: begin
        if (!s.sleeping && s.seq_mode < SM_LINK && lv.charge <= cfg.glow_charge_limit) begin
          s.pwm_delay  = 5'd0;
          s.led_level  = 1'b1;
          s.glow_delay = 5'd25;
        end
      end
      REQ_LAYER: begin
        if (layer_number == cfg.mouse_layer) begin
          s.layer_active = layer_on;
          if (layer_on) begin
            s = start_pwm(s);
          end else begin
            s = stop_pwm(s);
            s = settle(s, lv);
          end
        end
      end
      REQ_CYCLE: begin
        unique case (s.glow_mode)
          GM_OFF:     s.glow_mode = GM_DIM;
          GM_DIM:     s.glow_mode = GM_BREATHE;
          GM_BREATHE: s.glow_mode = GM_OFF;
          default:    s.glow_mode = GM_DIM;
        endcase
        s = stop_pwm(s);
        if (s.glow_mode == GM_OFF) begin
          s.led_level = 1'b1;
          s.seq_mode  = SM_PREVIEW_OFF;
          s.seq_delay = dly(50);
        end else begin
          s.preview_on   = 1'b1;
          s.preview_left = (s.glow_mode == GM_DIM) ? 7'd30 : 7'(BreathSteps);
          s = start_pwm(s);
        end
      end
      REQ_SLEEP: begin
        s.sleeping = 1'b1;
        s = stop_pwm(s);
        s.seq_delay  = '0;
        s.glow_delay = 5'd0;
        s.led_level  = 1'b0;
        s.seq_mode   = SM_IDLE;
      end
      REQ_WAKE: begin
        if (s.sleeping) begin
          s.sleeping = 1'b0;
          s = settle(s, lv);
        end
      end
      default: begin
        if (s.seq_mode < SM_LINK) s = settle(s, lv);
      end
    endcase
    // a started pwm runs its first step now; ending a preview may restart it once more
    if (s.kick) begin
      s.kick = 1'b0;
      s = pwm_fire(s, cfg, lv);
    end
    if (s.kick) begin
      s.kick = 1'b0;
      s = pwm_fire(s, cfg, lv);
    end
    st_nxt = s;
  end
endmodule

// ===== src/slps_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the status led pattern sequencer, bound to the top level
// depends on slps_pkg and status_led_pattern_sequencer

module slps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_led_on,
  input logic [2:0] out_show_mode,
  input logic [1:0] out_glow_mode,
  input logic       out_asleep
);
  import slps_pkg::*;

  // an empty result register never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("request stalled with empty output");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("transaction gave no result");

  // sleep clears the led and the pattern at once
  a_sleep_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_SLEEP |=>
      out_asleep && !out_led_on && out_show_mode == SM_IDLE)
    else $error("sleep result not dark and idle");

  a_glow_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_glow_mode != 2'd3) else $error("bad glow mode");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_on) && $stable(out_show_mode))
    else $error("stalled result changed");
endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req_type(in_ch.req_type),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_led_on(out_ch.led_on),
  .out_show_mode(out_ch.show_mode), .out_glow_mode(out_ch.glow_mode),
  .out_asleep(out_ch.asleep)
);
